// ----- rtl/core/scalar_kalman_filter_core_defines.svh -----
// Assertion macros shared by the scalar Kalman filter core.
`ifndef SCALAR_KALMAN_FILTER_CORE_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SKF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SKF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/skf_pkg.sv -----
// Constants, codes and controller/datapath types for the scalar Kalman filter core.
package skf_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int UVAL_W     = DATA_W - 1;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int DIV_W      = DATA_W + FRAC_W;
    localparam int DIV_RADIX  = 2;
    localparam int DIV_STEPS  = DIV_W / DIV_RADIX;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W  = 3;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 64;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSITION  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBSERVATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_EST    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VAR    = 3'd6;

    // Register reset values, Q16.16
    localparam logic signed [DATA_W-1:0] RST_TRANSITION  = 32'sd65536;
    localparam logic signed [DATA_W-1:0] RST_OBSERVATION = 32'sd65536;
    localparam logic signed [DATA_W-1:0] RST_CONTROL     = 32'sd0;
    localparam logic [UVAL_W-1:0]        RST_PROC_NOISE  = 31'd7;
    localparam logic [UVAL_W-1:0]        RST_MEAS_NOISE  = 31'd6554;
    localparam logic signed [DATA_W-1:0] RST_INIT_EST    = 32'sd196608;
    localparam logic [UVAL_W-1:0]        RST_INIT_VAR    = 31'd65536;

    localparam logic signed [DATA_W-1:0] VAL_ONE = DATA_W'(64'sd1 <<< FRAC_W);
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_WB,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    // One entry per shared multiply, in issue order
    typedef enum logic [3:0] {
        STEP_FX,
        STEP_BU,
        STEP_FP,
        STEP_TF,
        STEP_HXP,
        STEP_HPP,
        STEP_AH,
        STEP_PPH,
        STEP_KINN,
        STEP_KH,
        STEP_DPP
    } step_t;

    typedef struct packed {
        logic  load_in;
        logic  mul_issue;
        logic  wb;
        logic  div_start;
        logic  k_load;
        logic  result_load;
        step_t step;
    } dp_cmd_t;

    typedef struct packed {
        logic s_pos;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

// ----- rtl/core/skf_div.sv -----
// Restoring unsigned divider for the gain, two quotient bits per cycle.
module skf_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [skf_pkg::DIV_W-1:0]      dividend,
    input  logic [skf_pkg::UVAL_W-1:0]     divisor,
    output logic [skf_pkg::DIV_W-1:0]      quotient,
    output logic                           done
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [skf_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [skf_pkg::UVAL_W-1:0]        rem_reg;
    logic [skf_pkg::UVAL_W-1:0]        rem_next;
    logic [skf_pkg::DIV_W-1:0]         quo_reg;
    logic [skf_pkg::DIV_W-1:0]         quo_next;
    logic [skf_pkg::UVAL_W-1:0]        dvs_reg;

    // Shift dividend bits out at the top, quotient bits in at the bottom
    always_comb
    begin
        logic [skf_pkg::UVAL_W:0]  trial;
        logic [skf_pkg::UVAL_W-1:0] r;
        logic [skf_pkg::DIV_W-1:0]  q;
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < skf_pkg::DIV_RADIX; i++)
        begin
            trial = {r, q[skf_pkg::DIV_W-1]};
            q     = {q[skf_pkg::DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial = trial - {1'b0, dvs_reg};
                q[0]  = 1'b1;
            end
            r = trial[skf_pkg::UVAL_W-1:0];
        end
        rem_next = r;
        quo_next = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == skf_pkg::DIV_CNT_W'(skf_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

    `include "scalar_kalman_filter_core_defines.svh"

    `SKF_ASSERT_NEXT(a_div_runs, clk, rst_n, start, busy_reg && !done_reg, "divider did not start")

endmodule

// ----- rtl/core/skf_dp.sv -----
// Datapath: configuration and filter state, shared multiplier, divider and result register.
module skf_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [skf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]          cfg_wdata,
    input  logic [skf_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [skf_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  skf_pkg::dp_cmd_t                    cmd,
    output skf_pkg::dp_status_t                 status
);

    localparam int SH_W = skf_pkg::PROD_W - skf_pkg::FRAC_W;
    localparam int DW   = skf_pkg::DATA_W;
    localparam int UW   = skf_pkg::UVAL_W;

    // Configuration
    logic signed [DW-1:0] f_reg, h_reg, b_reg;
    logic [UW-1:0]        q_reg, r_reg;

    // Filter state
    logic signed [DW-1:0] est_reg;
    logic [UW-1:0]        var_reg;

    // Item operands and intermediates
    logic signed [DW-1:0] u_reg, z_reg;
    logic signed [DW-1:0] t_reg, xp_reg, pp_reg, inn_reg, s_reg, n_reg, k_reg;
    logic signed [skf_pkg::PROD_W-1:0] prod_reg;

    logic                             out_valid_reg;
    logic [skf_pkg::OUT_TDATA_W-1:0]  out_data_reg;

    logic signed [DW-1:0] op_a, op_b;
    logic signed [DW-1:0] fx;
    logic signed [DW-1:0] var_s, qn_s, rn_s;
    logic [DW-1:0]        n_mag;
    logic [skf_pkg::DIV_W-1:0] quotient;
    logic                 div_done;
    logic signed [DW-1:0] k_sat;

    function automatic logic signed [DW-1:0] sat_prod(input logic signed [skf_pkg::PROD_W-1:0] p);
        logic signed [SH_W-1:0] sh;
        logic [SH_W-DW:0]       top;
        sh  = SH_W'(p >>> skf_pkg::FRAC_W);
        top = sh[SH_W-1:DW-1];
        if ((&top) || !(|top))
            return sh[DW-1:0];
        else
            return sh[SH_W-1] ? skf_pkg::VAL_MIN : skf_pkg::VAL_MAX;
    endfunction

    function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                      input logic signed [DW-1:0] b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1])
            return s[DW] ? skf_pkg::VAL_MIN : skf_pkg::VAL_MAX;
        else
            return s[DW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] sat_sub(input logic signed [DW-1:0] a,
                                                      input logic signed [DW-1:0] b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} - {b[DW-1], b};
        if (s[DW] != s[DW-1])
            return s[DW] ? skf_pkg::VAL_MIN : skf_pkg::VAL_MAX;
        else
            return s[DW-1:0];
    endfunction

    assign var_s = $signed({1'b0, var_reg});
    assign qn_s  = $signed({1'b0, q_reg});
    assign rn_s  = $signed({1'b0, r_reg});
    assign fx    = sat_prod(prod_reg);

    // Operand select for the shared multiplier
    always_comb
    begin
        case (cmd.step)
            skf_pkg::STEP_FX:   begin op_a = f_reg;  op_b = est_reg; end
            skf_pkg::STEP_BU:   begin op_a = b_reg;  op_b = u_reg;   end
            skf_pkg::STEP_FP:   begin op_a = f_reg;  op_b = var_s;   end
            skf_pkg::STEP_TF:   begin op_a = t_reg;  op_b = f_reg;   end
            skf_pkg::STEP_HXP:  begin op_a = h_reg;  op_b = xp_reg;  end
            skf_pkg::STEP_HPP:  begin op_a = h_reg;  op_b = pp_reg;  end
            skf_pkg::STEP_AH:   begin op_a = t_reg;  op_b = h_reg;   end
            skf_pkg::STEP_PPH:  begin op_a = pp_reg; op_b = h_reg;   end
            skf_pkg::STEP_KINN: begin op_a = k_reg;  op_b = inn_reg; end
            skf_pkg::STEP_KH:   begin op_a = k_reg;  op_b = h_reg;   end
            skf_pkg::STEP_DPP:  begin op_a = t_reg;  op_b = pp_reg;  end
            default:            begin op_a = '0;     op_b = '0;      end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_issue)
            prod_reg <= op_a * op_b;
    end

    // Configuration registers and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_reg   <= skf_pkg::RST_TRANSITION;
            h_reg   <= skf_pkg::RST_OBSERVATION;
            b_reg   <= skf_pkg::RST_CONTROL;
            q_reg   <= skf_pkg::RST_PROC_NOISE;
            r_reg   <= skf_pkg::RST_MEAS_NOISE;
            est_reg <= skf_pkg::RST_INIT_EST;
            var_reg <= skf_pkg::RST_INIT_VAR;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                skf_pkg::CFG_TRANSITION:  f_reg <= cfg_wdata;
                skf_pkg::CFG_OBSERVATION: h_reg <= cfg_wdata;
                skf_pkg::CFG_CONTROL:     b_reg <= cfg_wdata;
                skf_pkg::CFG_PROC_NOISE:  q_reg <= cfg_wdata[UW-1:0];
                skf_pkg::CFG_MEAS_NOISE:  r_reg <= cfg_wdata[UW-1:0];
                // Initial values load straight into the filter state
                skf_pkg::CFG_INIT_EST:    est_reg <= cfg_wdata;
                skf_pkg::CFG_INIT_VAR:    var_reg <= cfg_wdata[UW-1:0];
                default: ;
            endcase
        end
        else if (cmd.wb && cmd.step == skf_pkg::STEP_KINN)
        begin
            est_reg <= sat_add(xp_reg, fx);
        end
        else if (cmd.wb && cmd.step == skf_pkg::STEP_DPP)
        begin
            // Clamp a negative variance to zero
            var_reg <= fx[DW-1] ? '0 : fx[UW-1:0];
        end
    end

    // Load the item operands, combine each product into its intermediate and load the gain
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            u_reg <= s_tdata[DW-1:0];
            z_reg <= s_tdata[2*DW-1:DW];
        end
        if (cmd.wb)
        begin
            case (cmd.step)
                skf_pkg::STEP_FX:  t_reg   <= fx;
                skf_pkg::STEP_BU:  xp_reg  <= sat_add(t_reg, fx);
                skf_pkg::STEP_FP:  t_reg   <= fx;
                skf_pkg::STEP_TF:  pp_reg  <= sat_add(fx, qn_s);
                skf_pkg::STEP_HXP: inn_reg <= sat_sub(z_reg, fx);
                skf_pkg::STEP_HPP: t_reg   <= fx;
                skf_pkg::STEP_AH:  s_reg   <= sat_add(fx, rn_s);
                skf_pkg::STEP_PPH:
                begin
                    n_reg <= fx;
                    k_reg <= '0;
                end
                skf_pkg::STEP_KH:  t_reg   <= sat_sub(skf_pkg::VAL_ONE, fx);
                default: ;
            endcase
        end
        if (cmd.k_load)
            k_reg <= k_sat;
    end

    // Gain division on magnitudes, sign applied afterwards
    assign n_mag = n_reg[DW-1] ? (~n_reg + 1'b1) : n_reg;

    skf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({n_mag, {skf_pkg::FRAC_W{1'b0}}}),
        .divisor  (s_reg[UW-1:0]),
        .quotient (quotient),
        .done     (div_done)
    );

    always_comb
    begin
        if (|quotient[skf_pkg::DIV_W-1:DW-1])
            k_sat = n_reg[DW-1] ? skf_pkg::VAL_MIN : skf_pkg::VAL_MAX;
        else if (n_reg[DW-1])
            k_sat = -$signed({1'b0, quotient[DW-2:0]});
        else
            k_sat = $signed({1'b0, quotient[DW-2:0]});
    end

    // Output register: hold the result until the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.result_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
            out_data_reg <= {1'b0, var_reg, est_reg};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign status.s_pos    = !s_reg[DW-1] && (|s_reg);
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || m_tready;

endmodule

// ----- rtl/core/skf_ctrl.sv -----
// Controller: sequences the shared multiplier, the gain division and the result hand-off.
module skf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  skf_pkg::dp_status_t   status,
    output skf_pkg::dp_cmd_t      cmd
);

    skf_pkg::state_t state_reg, state_next;
    skf_pkg::step_t  step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skf_pkg::ST_IDLE;
            step_reg  <= skf_pkg::STEP_FX;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        cmd.load_in     = 1'b0;
        cmd.mul_issue   = 1'b0;
        cmd.wb          = 1'b0;
        cmd.div_start   = 1'b0;
        cmd.k_load      = 1'b0;
        cmd.result_load = 1'b0;
        cmd.step        = step_reg;
        case (state_reg)
            skf_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    step_next   = skf_pkg::STEP_FX;
                    state_next  = skf_pkg::ST_MUL;
                end
            end
            skf_pkg::ST_MUL:
            begin
                cmd.mul_issue = 1'b1;
                state_next    = skf_pkg::ST_WB;
            end
            skf_pkg::ST_WB:
            begin
                cmd.wb = 1'b1;
                case (step_reg)
                    skf_pkg::STEP_FX:   begin step_next = skf_pkg::STEP_BU;  state_next = skf_pkg::ST_MUL; end
                    skf_pkg::STEP_BU:   begin step_next = skf_pkg::STEP_FP;  state_next = skf_pkg::ST_MUL; end
                    skf_pkg::STEP_FP:   begin step_next = skf_pkg::STEP_TF;  state_next = skf_pkg::ST_MUL; end
                    skf_pkg::STEP_TF:   begin step_next = skf_pkg::STEP_HXP; state_next = skf_pkg::ST_MUL; end
                    skf_pkg::STEP_HXP:  begin step_next = skf_pkg::STEP_HPP; state_next = skf_pkg::ST_MUL; end
                    skf_pkg::STEP_HPP:  begin step_next = skf_pkg::STEP_AH;  state_next = skf_pkg::ST_MUL; end
                    skf_pkg::STEP_AH:   begin step_next = skf_pkg::STEP_PPH; state_next = skf_pkg::ST_MUL; end
                    skf_pkg::STEP_PPH:
                    begin
                        // Skip the division and keep a zero gain when S is not positive
                        step_next  = skf_pkg::STEP_KINN;
                        state_next = status.s_pos ? skf_pkg::ST_DIV_GO : skf_pkg::ST_MUL;
                    end
                    skf_pkg::STEP_KINN: begin step_next = skf_pkg::STEP_KH;  state_next = skf_pkg::ST_MUL; end
                    skf_pkg::STEP_KH:   begin step_next = skf_pkg::STEP_DPP; state_next = skf_pkg::ST_MUL; end
                    skf_pkg::STEP_DPP:  state_next = skf_pkg::ST_OUT;
                    default:            state_next = skf_pkg::ST_IDLE;
                endcase
            end
            skf_pkg::ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = skf_pkg::ST_DIV_WAIT;
            end
            skf_pkg::ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.k_load = 1'b1;
                    state_next = skf_pkg::ST_MUL;
                end
            end
            skf_pkg::ST_OUT:
            begin
                // Wait for room in the output register
                if (status.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = skf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = skf_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == skf_pkg::ST_IDLE);

    `include "scalar_kalman_filter_core_defines.svh"

    `SKF_ASSERT_NEXT(a_item_start, clk, rst_n, s_tvalid && s_tready, state_reg == skf_pkg::ST_MUL && step_reg == skf_pkg::STEP_FX, "item transfer did not start the multiply sequence")
    `SKF_ASSERT_NOW(a_div_done_wait, clk, rst_n, status.div_done, state_reg == skf_pkg::ST_DIV_WAIT, "divider finished outside the wait state")
    `SKF_ASSERT_NOW(a_div_pos_s, clk, rst_n, state_reg == skf_pkg::ST_DIV_GO, status.s_pos, "division started with non-positive S")

endmodule

// ----- rtl/core/scalar_kalman_filter_core.sv -----
// Scalar Kalman filter core, signed Q16.16: one estimate and variance per transfer.
// Items are processed one at a time: eleven passes through the single shared 32x32
//   multiplier (issue plus write-back each) and, when S is positive, the gain divider;
//   a new item is taken only once the last result has entered the output register.
// Reset: registers return to their default values and the estimate and variance to
//   the initial values; the core accepts items as soon as reset is released.
module scalar_kalman_filter_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_wr_en,
    input  logic [skf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]          cfg_wdata,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [skf_pkg::IN_TDATA_W-1:0]      s_tdata,   // [31:0] control, [63:32] measurement
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [skf_pkg::OUT_TDATA_W-1:0]     m_tdata    // [31:0] estimate, [62:32] variance
);

    skf_pkg::dp_cmd_t    cmd;
    skf_pkg::dp_status_t status;

    skf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    skf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
